// ----- sv/rcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_pkg: shared types and constants of the cascaded RC low-pass filter
// Holds the field widths, register codes, queue entry and back-end state types.
// ----------------------------------------------------------------------------
package rcl_pkg;

	localparam int MAX_ORDER_DEF     = 8;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 16;
	localparam int RC_W       = 24;
	localparam int DEN_W      = RC_W + 1;
	localparam int INIT_W     = 16;
	localparam int STAGE_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int ORDER_FIELD_W = 4;

	localparam logic [RC_W-1:0] RC_TIME_RESET = RC_W'(1000);

	localparam logic MODE_FILTER  = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STAGE_COUNT   = 2'd0,
		CFG_INITIAL_VALUE = 2'd1,
		CFG_RC_TIME       = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_FILTER,
		OP_HOLD,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [SAMPLE_W-1:0] sample;
		logic [STEP_W-1:0]          time_step;
		logic [DEN_W-1:0]           den;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_ACC,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic busy;
		logic done_wait;
	} bk_status_t;

endpackage

// ----- sv/rcl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_front: request intake and classification
// Registers each request, forms the divider denominator and tags the request
// as filter, hold (zero denominator) or restart before it enters the queue.
// ----------------------------------------------------------------------------
module rcl_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 mode,
	input  logic signed [rcl_pkg::SAMPLE_W-1:0]  sample,
	input  logic [rcl_pkg::STEP_W-1:0]           time_step,
	input  logic [rcl_pkg::RC_W-1:0]             rc_time,
	output logic                                 q_push,
	input  logic                                 q_full,
	output rcl_pkg::cmd_t                        q_cmd
);
	import rcl_pkg::*;

	logic             valid_q;
	cmd_t             cmd_q;
	logic [DEN_W-1:0] den;
	logic             accept;

	assign den    = {1'b0, rc_time} + DEN_W'(time_step);
	assign full   = valid_q && q_full;
	assign accept = push && !full;
	assign q_push = valid_q;
	assign q_cmd  = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!q_full) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode == MODE_RESTART) begin
				cmd_q.op <= OP_RESTART;
			end else if (den == '0) begin
				cmd_q.op <= OP_HOLD;
			end else begin
				cmd_q.op <= OP_FILTER;
			end
			cmd_q.sample    <= sample;
			cmd_q.time_step <= time_step;
			cmd_q.den       <= den;
		end
	end

endmodule

// ----- sv/rcl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_queue: short command queue
// Decouples request intake from the stage arithmetic.
// ----------------------------------------------------------------------------
module rcl_queue #(
	parameter int DEPTH = rcl_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rcl_pkg::cmd_t wr_data,
	input  logic          pop,
	output logic          empty,
	output rcl_pkg::cmd_t rd_data
);
	import rcl_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- sv/rcl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_back: coefficient divider and stage sequencer
// Computes alpha one quotient bit per cycle, then updates the active stages
// one after another through a single multiplier, and holds the result.
// ----------------------------------------------------------------------------
module rcl_back #(
	parameter int MAX_ORDER     = rcl_pkg::MAX_ORDER_DEF,
	parameter int FRACTION_BITS = rcl_pkg::FRACTION_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_empty,
	output logic                                    q_pop,
	input  rcl_pkg::cmd_t                           q_cmd,
	input  logic [$clog2(MAX_ORDER+1)-1:0]          stage_count,
	input  logic signed [rcl_pkg::INIT_W-1:0]       initial_value,
	output logic signed [rcl_pkg::STAGE_W-1:0]      filtered,
	output logic                                    empty,
	input  logic                                    pop,
	output rcl_pkg::bk_status_t                     status
);
	import rcl_pkg::*;

	localparam int F      = FRACTION_BITS;
	localparam int IW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int DCW    = $clog2(F + 1);
	localparam int FX_W   = (SAMPLE_W + F > STAGE_W + 1) ? SAMPLE_W + F : STAGE_W + 1;
	localparam int PROD_W = F + 2 + STAGE_W + 1;

	bk_state_t state_q, state_d;

	logic signed [STAGE_W-1:0] stage_q [MAX_ORDER];
	logic [F:0]                alpha_q;
	logic [DEN_W-1:0]          rem_q;
	logic [DEN_W-1:0]          den_q;
	logic [DCW-1:0]            div_cnt_q;
	logic [IW-1:0]             idx_q;
	logic signed [STAGE_W-1:0] prev_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [STAGE_W-1:0] out_q;
	logic                      out_valid_q;

	logic                      out_free;
	logic                      load_out;
	logic [IW-1:0]             last_idx;
	logic signed [STAGE_W-1:0] cur;
	logic signed [STAGE_W:0]   diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [STAGE_W-1:0] upd;
	logic [DEN_W:0]            rem_x2;
	logic                      ge;
	logic                      top_bit;
	logic signed [STAGE_W-1:0] init_fx;
	logic signed [STAGE_W-1:0] sample_fx;

	// Integer to fixed point, saturated to the 32-bit signed range.
	function automatic logic signed [STAGE_W-1:0] to_fixed(
		input logic signed [SAMPLE_W-1:0] v
	);
		logic signed [FX_W-1:0] f;
		f = FX_W'(signed'({v, {F{1'b0}}}));
		if ((&f[FX_W-1:STAGE_W-1]) || !(|f[FX_W-1:STAGE_W-1])) begin
			return f[STAGE_W-1:0];
		end
		return f[FX_W-1] ? {1'b1, {(STAGE_W-1){1'b0}}} : {1'b0, {(STAGE_W-1){1'b1}}};
	endfunction

	assign init_fx   = to_fixed(initial_value);
	assign sample_fx = to_fixed(q_cmd.sample);
	assign last_idx  = IW'(stage_count - 1'b1);

	// The quotient never exceeds one, so its top bit is settled by a compare.
	assign top_bit = ({{(DEN_W-STEP_W){1'b0}}, q_cmd.time_step} >= q_cmd.den);
	assign rem_x2  = {rem_q, 1'b0};
	assign ge      = (rem_x2 >= {1'b0, den_q});

	assign cur  = stage_q[idx_q];
	assign diff = $signed({prev_q[STAGE_W-1], prev_q}) - $signed({cur[STAGE_W-1], cur});
	assign prod = $signed({1'b0, alpha_q}) * diff;
	// The arithmetic shift of the product floors; the sum stays between both stages.
	assign upd  = cur + prod_s1[F+STAGE_W-1:F];

	assign out_free = !out_valid_q || pop;
	assign load_out = (state_q == BK_DONE) && out_free;
	assign empty    = !out_valid_q;
	assign filtered = out_q;

	assign status.busy      = (state_q != BK_IDLE);
	assign status.done_wait = (state_q == BK_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_cmd.op == OP_FILTER) ? BK_DIV : BK_DONE;
				end
			end
			BK_DIV: begin
				if (div_cnt_q == DCW'(1)) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_ACC;
			end
			BK_ACC: begin
				state_d = (idx_q == last_idx) ? BK_DONE : BK_MUL;
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				stage_q[i] <= '0;
			end
		end else if (q_pop && q_cmd.op == OP_RESTART) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				stage_q[i] <= init_fx;
			end
		end else if (state_q == BK_ACC) begin
			stage_q[idx_q] <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			alpha_q   <= {{F{1'b0}}, top_bit};
			rem_q     <= DEN_W'({{(DEN_W-STEP_W){1'b0}}, q_cmd.time_step})
				- (top_bit ? q_cmd.den : '0);
			den_q     <= q_cmd.den;
			div_cnt_q <= DCW'(F);
			idx_q     <= '0;
			prev_q    <= sample_fx;
		end
		if (state_q == BK_DIV) begin
			alpha_q   <= {alpha_q[F-1:0], ge};
			rem_q     <= ge ? DEN_W'(rem_x2 - {1'b0, den_q}) : rem_x2[DEN_W-1:0];
			div_cnt_q <= DCW'(div_cnt_q - 1'b1);
		end
		if (state_q == BK_MUL) begin
			prod_s1 <= prod;
		end
		if (state_q == BK_ACC) begin
			prev_q <= upd;
			if (idx_q != last_idx) begin
				idx_q <= IW'(idx_q + 1'b1);
			end
		end
		if (load_out) begin
			out_q <= stage_q[last_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/cascaded_rc_lowpass_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_rc_lowpass_filter: cascade of first-order RC low-pass stages
// Queue-style request and result ports, plus a register write channel.
// ----------------------------------------------------------------------------
// Each filter request computes alpha = time_step / (rc_time + time_step) with
// FRACTION_BITS fraction bits in a bit-serial divider (one quotient bit per
// cycle), then updates stages 1..stage_count one at a time through one shared
// multiplier, in a multiply state and then an accumulate state per stage. A
// restart or a request with a zero denominator goes straight to the done
// state. A small command queue lets requests be pushed while the back end is
// busy, and the result waits in its own register until popped. The result is
// the last active stage in signed fixed point. Stage count writes saturate to
// 1..MAX_ORDER; initial_value takes effect at the next restart. Registers are
// to be written only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module cascaded_rc_lowpass_filter #(
	parameter int MAX_ORDER     = rcl_pkg::MAX_ORDER_DEF,
	parameter int FRACTION_BITS = rcl_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  mode,
	input  logic signed [rcl_pkg::SAMPLE_W-1:0]   sample,
	input  logic [rcl_pkg::STEP_W-1:0]            time_step,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [rcl_pkg::STAGE_W-1:0]    filtered,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rcl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rcl_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import rcl_pkg::*;

	localparam int SCW = $clog2(MAX_ORDER + 1);

	logic [SCW-1:0]           stage_count_q;
	logic signed [INIT_W-1:0] initial_value_q;
	logic [RC_W-1:0]          rc_time_q;
	logic [ORDER_FIELD_W-1:0] order_field;

	logic       fq_push;
	logic       fq_full;
	cmd_t       fq_cmd;
	logic       q_empty;
	logic       q_pop;
	cmd_t       q_cmd;
	bk_status_t bk_stat;

	assign cfg_ready   = 1'b1;
	assign order_field = cfg_data[ORDER_FIELD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q   <= SCW'(1);
			initial_value_q <= '0;
			rc_time_q       <= RC_TIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STAGE_COUNT: begin
					if (order_field == '0) begin
						stage_count_q <= SCW'(1);
					end else if (int'(order_field) > MAX_ORDER) begin
						stage_count_q <= SCW'(MAX_ORDER);
					end else begin
						stage_count_q <= SCW'(order_field);
					end
				end
				CFG_INITIAL_VALUE: begin
					initial_value_q <= cfg_data[INIT_W-1:0];
				end
				CFG_RC_TIME: begin
					rc_time_q <= cfg_data[RC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rcl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.sample    (sample),
		.time_step (time_step),
		.rc_time   (rc_time_q),
		.q_push    (fq_push),
		.q_full    (fq_full),
		.q_cmd     (fq_cmd)
	);

	rcl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.full    (fq_full),
		.wr_data (fq_cmd),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_cmd)
	);

	rcl_back #(
		.MAX_ORDER     (MAX_ORDER),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_cmd         (q_cmd),
		.stage_count   (stage_count_q),
		.initial_value (initial_value_q),
		.filtered      (filtered),
		.empty         (empty),
		.pop           (pop),
		.status        (bk_stat)
	);

	// The filter order register never leaves its legal range.
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_count_q >= SCW'(1)) && (int'(stage_count_q) <= MAX_ORDER))
		else $error("stage count out of range");

	// The back end takes a new command only when it has finished the last one.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !bk_stat.busy)
		else $error("command taken while back end busy");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> bk_stat.busy)
		else $error("back end did not start after taking a command");

	// A finished command reaches the result register as soon as it is free.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_stat.done_wait && (empty || pop)) |=> !empty)
		else $error("finished result not delivered");

endmodule
